### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the RTL; every check runs on the rising
// edge of clock and is off while reset is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that must hold at every edge
`define DSC_ASSERT_ALWAYS(name, cond) \
   name: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("invariant violated");

// consequent checked in the same cycle as the antecedent
`define DSC_ASSERT_IMPL(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("implication violated");

// consequent checked in the cycle after the antecedent
`define DSC_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");

`endif

### hdl/dsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsc_pkg
// Shared types and constants of the dual stack block.
// ----------------------------------------------------------------------------
package dsc_pkg;

   // default stack capacity in words
   localparam int DEPTH_DEFAULT = 128;

   // fixed field widths
   localparam int DATA_W    = 32;
   localparam int KIND_W    = 2;
   localparam int ERR_W     = 2;
   localparam int DEPTH_O_W = 8;

   // operation codes
   typedef enum logic [KIND_W-1:0] {
      KIND_PUSH   = 2'd0,
      KIND_POP    = 2'd1,
      KIND_PEEK   = 2'd2,
      KIND_CONCAT = 2'd3
   } kind_type;

   // result codes
   typedef enum logic [ERR_W-1:0] {
      ERR_OK    = 2'd0,
      ERR_FULL  = 2'd1,
      ERR_EMPTY = 2'd2
   } err_type;

   // shared adder operation
   typedef enum logic {
      ALU_ADD = 1'b0,
      ALU_SUB = 1'b1
   } alu_op_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE   = 3'd0,
      ST_EXEC   = 3'd1,
      ST_READ   = 3'd2,
      ST_COPY   = 3'd3,
      ST_FINISH = 3'd4,
      ST_RESP   = 3'd5
   } state_type;

endpackage

### hdl/dsc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsc_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module dsc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### hdl/dsc_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsc_alu
// Shared add/subtract unit for stack counts and RAM addresses.
// ----------------------------------------------------------------------------
module dsc_alu #(
   parameter int W = 8
) (
   input  logic [W-1:0]        a,
   input  logic [W-1:0]        b,
   input  dsc_pkg::alu_op_type op,
   output logic [W:0]          y
);
   import dsc_pkg::*;

   // one extra bit keeps the carry for overflow compares
   always_comb begin
      unique case (op)
         ALU_ADD: y = {1'b0, a} + {1'b0, b};
         ALU_SUB: y = {1'b0, a} - {1'b0, b};
         default: y = '0;
      endcase
   end

endmodule

### hdl/dual_stack_with_concat.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_stack_with_concat
// Push, refused operations and an empty-source concat go from exec straight to
// the response; pop and peek pass a read state first. New requests are taken
// only in idle. A concat moves one word per cycle in the copy state through the
// destination stack's RAM write port; counts and addresses share one adder.
// Synchronous reset empties both stacks; RAM contents are not cleared.
// Results are a one-cycle strobe; the receiver cannot stall.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dual_stack_with_concat #(
   parameter int DEPTH = dsc_pkg::DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [dsc_pkg::KIND_W-1:0]    req_kind,
   input  logic                          req_which_stack,
   input  logic [dsc_pkg::DATA_W-1:0]    req_push_value,
   output logic                          rsp_valid,
   output logic [dsc_pkg::DATA_W-1:0]    rsp_read_value,
   output logic [dsc_pkg::ERR_W-1:0]     rsp_error_code,
   output logic [dsc_pkg::DEPTH_O_W-1:0] rsp_depth_after,
   output logic                          rsp_is_empty
);
   import dsc_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int IW = AW + 1;

   state_type         state_ff, state_in;
   kind_type          kind_ff, kind_in;
   logic              sel_ff, sel_in;
   logic [DATA_W-1:0] value_ff, value_in;
   logic [DATA_W-1:0] rd_ff, rd_in;
   err_type           err_ff, err_in;
   logic [CW-1:0]     cnt_a_ff, cnt_a_in;
   logic [CW-1:0]     cnt_b_ff, cnt_b_in;
   logic [AW-1:0]     idx_ff, idx_in;

   logic [CW-1:0]     cnt_sel, cnt_oth, cnt_sel_in, cnt_oth_in;
   logic [IW-1:0]     idx_inc;
   logic              copy_last;
   logic              push_full, sel_empty, concat_over, src_empty;
   logic              push_refused;

   logic [CW-1:0]     alu_b;
   alu_op_type        alu_op;
   logic [CW:0]       alu_y;

   logic [1:0]        ram_we;
   logic [AW-1:0]     ram_waddr, ram_raddr;
   logic [DATA_W-1:0] ram_wdata;
   logic [DATA_W-1:0] rdata_a, rdata_b, rdata_sel, rdata_oth;

   // selected and other stack views
   assign cnt_sel   = sel_ff ? cnt_b_ff : cnt_a_ff;
   assign cnt_oth   = sel_ff ? cnt_a_ff : cnt_b_ff;
   assign rdata_sel = sel_ff ? rdata_b : rdata_a;
   assign rdata_oth = sel_ff ? rdata_a : rdata_b;

   // copy index bookkeeping
   assign idx_inc   = IW'(idx_ff) + IW'(1);
   assign copy_last = (idx_inc == IW'(cnt_oth));

   // operand select for the shared adder
   always_comb begin
      alu_b  = '0;
      alu_op = ALU_ADD;
      unique case (state_ff)
         ST_EXEC: begin
            unique case (kind_ff) inside
               KIND_PUSH: alu_b = CW'(1);
               KIND_POP, KIND_PEEK: begin
                  alu_b  = CW'(1);
                  alu_op = ALU_SUB;
               end
               KIND_CONCAT: alu_b = cnt_oth;
               default: alu_b = '0;
            endcase
         end
         ST_READ: begin
            alu_b  = CW'(1);
            alu_op = ALU_SUB;
         end
         ST_COPY:   alu_b = CW'(idx_ff);
         ST_FINISH: alu_b = cnt_oth;
         default:   alu_b = '0;
      endcase
   end

   dsc_alu #(
      .W (CW)
   ) u_alu (
      .a  (cnt_sel),
      .b  (alu_b),
      .op (alu_op),
      .y  (alu_y)
   );

   // operation checks
   assign push_full   = (cnt_sel >= CW'(DEPTH));
   assign sel_empty   = (cnt_sel == '0);
   assign concat_over = (alu_y > (CW + 1)'(DEPTH));
   assign src_empty   = (cnt_oth == '0);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            unique case (kind_ff) inside
               KIND_PUSH: state_in = ST_RESP;
               KIND_POP, KIND_PEEK: state_in = sel_empty ? ST_RESP : ST_READ;
               KIND_CONCAT: state_in = (concat_over || src_empty) ? ST_RESP : ST_COPY;
               default: state_in = ST_RESP;
            endcase
         end
         ST_READ: state_in = ST_RESP;
         ST_COPY: begin
            if (copy_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: state_in = ST_RESP;
         ST_RESP:   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs: handshake and RAM ports
   always_comb begin
      busy      = (state_ff != ST_IDLE);
      rsp_valid = (state_ff == ST_RESP);
      ram_we    = '0;
      ram_waddr = cnt_sel[AW-1:0];
      ram_wdata = value_ff;
      ram_raddr = '0;
      unique case (state_ff)
         ST_EXEC: begin
            unique case (kind_ff) inside
               KIND_PUSH: begin
                  if (!push_full) begin
                     ram_we[sel_ff] = 1'b1;
                  end
               end
               KIND_POP, KIND_PEEK: ram_raddr = alu_y[AW-1:0];
               default: ram_raddr = '0;
            endcase
         end
         ST_COPY: begin
            ram_we[sel_ff] = 1'b1;
            ram_waddr      = alu_y[AW-1:0];
            ram_wdata      = rdata_oth;
            ram_raddr      = idx_inc[AW-1:0];
         end
         default: ram_raddr = '0;
      endcase
   end

   // datapath next values
   always_comb begin
      kind_in    = kind_ff;
      sel_in     = sel_ff;
      value_in   = value_ff;
      rd_in      = rd_ff;
      err_in     = err_ff;
      idx_in     = idx_ff;
      cnt_sel_in = cnt_sel;
      cnt_oth_in = cnt_oth;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               kind_in  = kind_type'(req_kind);
               sel_in   = req_which_stack;
               value_in = req_push_value;
            end
         end
         ST_EXEC: begin
            rd_in  = '0;
            err_in = ERR_OK;
            idx_in = '0;
            unique case (kind_ff) inside
               KIND_PUSH: begin
                  if (push_full) begin
                     err_in = ERR_FULL;
                  end else begin
                     cnt_sel_in = alu_y[CW-1:0];
                  end
               end
               KIND_POP, KIND_PEEK: begin
                  if (sel_empty) begin
                     err_in = ERR_EMPTY;
                  end
               end
               KIND_CONCAT: begin
                  if (concat_over) begin
                     err_in = ERR_FULL;
                  end
               end
               default: err_in = ERR_OK;
            endcase
         end
         ST_READ: begin
            rd_in = rdata_sel;
            if (kind_ff == KIND_POP) begin
               cnt_sel_in = alu_y[CW-1:0];
            end
         end
         ST_COPY: idx_in = idx_inc[AW-1:0];
         ST_FINISH: begin
            cnt_sel_in = alu_y[CW-1:0];
            cnt_oth_in = '0;
         end
         default: rd_in = rd_ff;
      endcase
      cnt_a_in = sel_ff ? cnt_oth_in : cnt_sel_in;
      cnt_b_in = sel_ff ? cnt_sel_in : cnt_oth_in;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_a_ff <= '0;
         cnt_b_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_a_ff <= cnt_a_in;
         cnt_b_ff <= cnt_b_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      sel_ff   <= sel_in;
      value_ff <= value_in;
      rd_ff    <= rd_in;
      err_ff   <= err_in;
      idx_ff   <= idx_in;
   end

   // word storage, one RAM per stack
   dsc_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_ram_a (
      .clock (clock),
      .we    (ram_we[0]),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (rdata_a)
   );

   dsc_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_ram_b (
      .clock (clock),
      .we    (ram_we[1]),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (rdata_b)
   );

   // result transfer
   assign rsp_read_value  = rd_ff;
   assign rsp_error_code  = ERR_W'(err_ff);
   assign rsp_depth_after = DEPTH_O_W'(cnt_sel);
   assign rsp_is_empty    = sel_empty;

   // refused push seen on the result strobe
   assign push_refused = rsp_valid && (kind_ff == KIND_PUSH) && (err_ff == ERR_FULL);

   // checks
   `DSC_ASSERT_ALWAYS(a_cnt_bound, (cnt_a_ff <= CW'(DEPTH)) && (cnt_b_ff <= CW'(DEPTH)))
   `DSC_ASSERT_ALWAYS(a_one_writer, !(ram_we[0] && ram_we[1]))
   `DSC_ASSERT_NEXT(a_src_drained, state_ff == ST_FINISH, cnt_oth == '0)
   `DSC_ASSERT_IMPL(a_full_push, push_refused, cnt_sel == CW'(DEPTH))

endmodule
